[rtl/core/stopwatch_with_key_debounce_display_defines.svh]
// Assertion macros for the stopwatch core.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef STOPWATCH_WITH_KEY_DEBOUNCE_DISPLAY_DEFINES_SVH
`define STOPWATCH_WITH_KEY_DEBOUNCE_DISPLAY_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define SWD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that an implication holds on the following clock edge.
`define SWD_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

[rtl/core/swd_pkg.sv]
// Shared types, constants and the glyph table of the stopwatch core.
// No dependencies.
`timescale 1ns / 1ps

package swd_pkg;

  localparam int KEY_W       = 4;
  localparam int TPC_W       = 8;
  localparam int HUND_W      = 7;
  localparam int SEC_W       = 14;
  localparam int SCAN_W      = 3;
  localparam int SEG_W       = 8;
  localparam int BCD_W       = 4;
  localparam int NUM_DIGITS  = 6;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_FIELD_W = SCAN_W + SEG_W + 1 + HUND_W + SEC_W;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam int DEF_DEBOUNCE_SAMPLES = 8;
  localparam int DEF_NUM_KEYS         = 4;

  localparam int KEY_CLEAR  = 1;
  localparam int KEY_TOGGLE = 2;

  localparam logic [0:0]        REG_TICKS_PER_COUNT = 1'b0;
  localparam logic [TPC_W-1:0]  TPC_RESET           = 8'd5;
  localparam logic [HUND_W-1:0] HUND_MAX            = 7'd99;
  localparam logic [SEC_W-1:0]  SEC_MAX             = 14'd9999;
  localparam logic [BCD_W-1:0]  BCD_NINE            = 4'd9;
  localparam logic [SEG_W-1:0]  SEG_BLANK           = 8'hFF;
  localparam logic [SEG_W-1:0]  SEG_POINT_CLEAR     = 8'h7F;

  localparam logic [SCAN_W-1:0] DIG_HUND_UNITS = 3'd0;
  localparam logic [SCAN_W-1:0] DIG_HUND_TENS  = 3'd1;
  localparam logic [SCAN_W-1:0] DIG_SEC_UNITS  = 3'd2;
  localparam logic [SCAN_W-1:0] DIG_SEC_TENS   = 3'd3;
  localparam logic [SCAN_W-1:0] DIG_SEC_HUNDS  = 3'd4;
  localparam logic [SCAN_W-1:0] DIG_SEC_THOUS  = 3'd5;
  localparam logic [SCAN_W-1:0] DIG_LAST       = SCAN_W'(NUM_DIGITS - 1);

  typedef logic [BCD_W-1:0] bcd_t;

  typedef struct packed {
    logic clear;
    logic toggle;
  } key_evt_t;

  typedef struct packed {
    logic [HUND_W-1:0] hund;
    logic [SEC_W-1:0]  sec;
    bcd_t [1:0]        hund_bcd;
    bcd_t [3:0]        sec_bcd;
  } counts_t;

  function automatic logic [SEG_W-1:0] glyph(input bcd_t d);
    logic [SEG_W-1:0] g;
    case (d)
      4'd0:    g = 8'hC0;
      4'd1:    g = 8'hF9;
      4'd2:    g = 8'hA4;
      4'd3:    g = 8'hB0;
      4'd4:    g = 8'h99;
      4'd5:    g = 8'h92;
      4'd6:    g = 8'h82;
      4'd7:    g = 8'hF8;
      4'd8:    g = 8'h80;
      4'd9:    g = 8'h90;
      default: g = SEG_BLANK;
    endcase
    return g;
  endfunction

endpackage

[rtl/core/swd_debounce.sv]
// Per-key shift-history debounce and stable falling edge detection.
// Depends on swd_pkg.
`timescale 1ns / 1ps

module swd_debounce import swd_pkg::*; #(
  parameter int DEBOUNCE_SAMPLES = DEF_DEBOUNCE_SAMPLES,
  parameter int NUM_KEYS         = DEF_NUM_KEYS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [KEY_W-1:0] levels_i,
  output key_evt_t         evt_o
);

  logic [NUM_KEYS-1:0]                       lv;
  logic [NUM_KEYS-1:0][DEBOUNCE_SAMPLES-1:0] hist_q, hist_d;
  logic [NUM_KEYS-1:0]                       stable_q, stable_d;
  logic [NUM_KEYS-1:0]                       fall;

  for (genvar g = 0; g < NUM_KEYS; g++) begin : g_lv
    if (g < KEY_W) begin : g_in
      assign lv[g] = levels_i[g];
    end else begin : g_zero
      assign lv[g] = 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_KEYS; i++) begin
      hist_d[i]   = {hist_q[i][DEBOUNCE_SAMPLES-2:0], lv[i]};
      stable_d[i] = stable_q[i];
      if (hist_d[i] == '0) begin
        stable_d[i] = 1'b0;
      end else if (hist_d[i] == '1) begin
        stable_d[i] = 1'b1;
      end
    end
    fall         = stable_q & ~stable_d;
    evt_o.clear  = fall[KEY_CLEAR];
    evt_o.toggle = fall[KEY_TOGGLE];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q   <= '1;
      stable_q <= '1;
    end else if (en_i) begin
      hist_q   <= hist_d;
      stable_q <= stable_d;
    end
  end

endmodule

[rtl/core/swd_counter.sv]
// Run flag, tick divider and the binary and decimal stopwatch counts.
// Depends on swd_pkg.
`timescale 1ns / 1ps

module swd_counter import swd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  key_evt_t         evt_i,
  input  logic [TPC_W-1:0] tpc_i,
  output logic             run_o,
  output counts_t          counts_o
);

  logic             run_q, run_d;
  logic [TPC_W-1:0] div_q, div_d, div_inc;
  logic             fire;
  counts_t          cnt_q, cnt_d;
  logic             carry;

  always_comb begin
    run_d = run_q;
    cnt_d = cnt_q;
    if (evt_i.clear) begin
      run_d = 1'b0;
      cnt_d = '0;
    end
    if (evt_i.toggle) begin
      run_d = ~run_d;
    end

    div_inc = div_q + TPC_W'(1);
    fire    = (div_inc >= tpc_i);
    div_d   = fire ? '0 : div_inc;

    carry = 1'b0;
    if (fire && run_d) begin
      cnt_d.hund = (cnt_d.hund == HUND_MAX) ? '0 : cnt_d.hund + HUND_W'(1);
      if (cnt_d.hund_bcd[0] == BCD_NINE) begin
        cnt_d.hund_bcd[0] = '0;
        if (cnt_d.hund_bcd[1] == BCD_NINE) begin
          cnt_d.hund_bcd[1] = '0;
          carry             = 1'b1;
        end else begin
          cnt_d.hund_bcd[1] = cnt_d.hund_bcd[1] + BCD_W'(1);
        end
      end else begin
        cnt_d.hund_bcd[0] = cnt_d.hund_bcd[0] + BCD_W'(1);
      end
    end

    if (carry) begin
      cnt_d.sec = (cnt_d.sec == SEC_MAX) ? '0 : cnt_d.sec + SEC_W'(1);
    end
    for (int k = 0; k < 4; k++) begin
      if (carry) begin
        if (cnt_d.sec_bcd[k] == BCD_NINE) begin
          cnt_d.sec_bcd[k] = '0;
        end else begin
          cnt_d.sec_bcd[k] = cnt_d.sec_bcd[k] + BCD_W'(1);
          carry            = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      div_q <= '0;
      cnt_q <= '0;
    end else if (en_i) begin
      run_q <= run_d;
      div_q <= div_d;
      cnt_q <= cnt_d;
    end
  end

  assign run_o    = run_d;
  assign counts_o = cnt_d;

endmodule

[rtl/core/swd_display.sv]
// Digit scan index and seven-segment pattern with leading-zero blanking.
// Depends on swd_pkg.
`timescale 1ns / 1ps

module swd_display import swd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  counts_t           counts_i,
  output logic [SCAN_W-1:0] scan_o,
  output logic [SEG_W-1:0]  seg_o
);

  logic [SCAN_W-1:0] scan_q, scan_d;
  bcd_t [3:0]        s;

  assign s = counts_i.sec_bcd;

  always_comb begin
    scan_d = (scan_q == DIG_LAST) ? '0 : scan_q + SCAN_W'(1);
    unique case (scan_q)
      DIG_HUND_UNITS: seg_o = glyph(counts_i.hund_bcd[0]);
      DIG_HUND_TENS:  seg_o = glyph(counts_i.hund_bcd[1]);
      DIG_SEC_UNITS:  seg_o = glyph(s[0]) & SEG_POINT_CLEAR;
      DIG_SEC_TENS:   seg_o = ((s[1] | s[2] | s[3]) != '0) ? glyph(s[1]) : SEG_BLANK;
      DIG_SEC_HUNDS:  seg_o = ((s[2] | s[3]) != '0) ? glyph(s[2]) : SEG_BLANK;
      DIG_SEC_THOUS:  seg_o = (s[3] != '0) ? glyph(s[3]) : SEG_BLANK;
      default:        seg_o = SEG_BLANK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
    end else if (en_i) begin
      scan_q <= scan_d;
    end
  end

  assign scan_o = scan_q;

endmodule

[rtl/core/stopwatch_with_key_debounce_display.sv]
// Channel    | dir | tdata fields (low bit up)
// s_axis     | in  | key_levels[3:0], zero pad to 8 bits
// m_axis     | out | scan_digit[2:0] segments[10:3] running[11]
//            |     | hundredths[18:12] whole_seconds[32:19], zero pad to 40
// apb        | cfg | word 0: ticks_per_count[7:0]
// Each item passes an input register, then the key, count and display
// logic into the result register, one item per cycle sustained while
// m_axis_tready is high. The result register holds while it is low;
// the input register keeps taking an item as soon as the result moves on.
// Reset clears all key histories to released and the counts to zero.
`timescale 1ns / 1ps

`include "stopwatch_with_key_debounce_display_defines.svh"

module stopwatch_with_key_debounce_display import swd_pkg::*; #(
  parameter int DEBOUNCE_SAMPLES = DEF_DEBOUNCE_SAMPLES,
  parameter int NUM_KEYS         = DEF_NUM_KEYS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // key_levels[3:0]
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // scan_digit, segments, running,
                                                // hundredths, whole_seconds
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_W-1:0]     paddr,
  input  logic [PDATA_W-1:0]     pwdata,
  output logic [PDATA_W-1:0]     prdata,
  output logic                   pready
);

  logic                   in_vld_q;
  logic [KEY_W-1:0]       keys_q;
  logic                   out_vld_q;
  logic [OUT_FIELD_W-1:0] out_q;
  logic                   s_acc, adv;
  logic [TPC_W-1:0]       tpc_q;
  key_evt_t               evt;
  logic                   run;
  counts_t                counts;
  logic [SCAN_W-1:0]      scan;
  logic [SEG_W-1:0]       seg;

  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1] == REG_TICKS_PER_COUNT)
                  ? PDATA_W'(tpc_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpc_q <= TPC_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr[PADDR_W-1] == REG_TICKS_PER_COUNT) begin
      tpc_q <= pwdata[TPC_W-1:0];
    end
  end

  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_acc) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      keys_q <= s_axis_tdata[KEY_W-1:0];
    end
    if (adv) begin
      out_q <= {counts.sec, counts.hund, run, seg, scan};
    end
  end

  swd_debounce #(
    .DEBOUNCE_SAMPLES (DEBOUNCE_SAMPLES),
    .NUM_KEYS         (NUM_KEYS)
  ) u_debounce (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .levels_i (keys_q),
    .evt_o    (evt)
  );

  swd_counter u_counter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .evt_i    (evt),
    .tpc_i    (tpc_q),
    .run_o    (run),
    .counts_o (counts)
  );

  swd_display u_display (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .counts_i (counts),
    .scan_o   (scan),
    .seg_o    (seg)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_FIELD_W){1'b0}}, out_q};

  `SWD_ASSERT(a_hund_range, !out_vld_q || out_q[18:12] <= HUND_MAX, "hundredths out of range")
  `SWD_ASSERT(a_sec_range, !out_vld_q || out_q[32:19] <= SEC_MAX, "seconds out of range")
  `SWD_ASSERT(a_scan_range, !out_vld_q || out_q[2:0] <= DIG_LAST, "scan digit out of range")
  `SWD_ASSERT_NEXT(a_hold_item, in_vld_q && out_vld_q && !m_axis_tready, in_vld_q, "item lost")

endmodule
